/* rtl/ehklt_pkg.sv */
// ----------------------------------------------------------------------------
// ehklt_pkg
// Shared types, codes and the ELF hash step for the keyed lookup table.
// ----------------------------------------------------------------------------
package ehklt_pkg;

	localparam int unsigned DEPTH_DEFAULT = 64;

	localparam int unsigned KEY_W   = 32;
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned HASH_W  = 31;
	localparam int unsigned STAT_W  = 2;

	localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_HIT      = 2'd2;
	localparam logic [STAT_W-1:0] ST_MISS     = 2'd3;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [KEY_W-1:0] HASH_TOP_MASK = 32'hf000_0000;
	localparam int unsigned      HASH_FOLD_SH  = 24;
	localparam int unsigned      HASH_SHIFT    = 4;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic scan_issue;
		logic finish;
	} ehklt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic key_end;
		logic tbl_empty;
		logic out_free;
		logic cmp_valid;
		logic cmp_hit;
		logic cmp_last;
	} ehklt_stat_t;

	function automatic logic [KEY_W-1:0] hash_step(input logic [KEY_W-1:0] h_in,
		input logic [BYTE_W-1:0] b);
		logic [KEY_W-1:0] h;
		logic [KEY_W-1:0] top;
		h   = (h_in << HASH_SHIFT) + {{(KEY_W-BYTE_W){1'b0}}, b};
		top = h & HASH_TOP_MASK;
		if (top != '0) begin
			h = (h ^ (top >> HASH_FOLD_SH)) & ~top;
		end
		return h;
	endfunction

endpackage

/* rtl/ehklt_req_if.sv */
// ----------------------------------------------------------------------------
// ehklt_req_if
// Request channel: insert entries and stream lookup key bytes.
// ----------------------------------------------------------------------------
interface ehklt_req_if;
	logic                            valid;
	logic                            ready;
	logic                            command;
	logic [ehklt_pkg::KEY_W-1:0]     new_key;
	logic [ehklt_pkg::VAL_W-1:0]     entry_value;
	logic [ehklt_pkg::BYTE_W-1:0]    key_byte;

	modport source (output valid, command, new_key, entry_value, key_byte, input ready);
	modport sink   (input valid, command, new_key, entry_value, key_byte, output ready);
endinterface

/* rtl/ehklt_rsp_if.sv */
// ----------------------------------------------------------------------------
// ehklt_rsp_if
// Response channel: insert status or lookup result.
// ----------------------------------------------------------------------------
interface ehklt_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [ehklt_pkg::STAT_W-1:0]    status;
	logic [ehklt_pkg::VAL_W-1:0]     found_value;
	logic [ehklt_pkg::HASH_W-1:0]    key_hash;

	modport source (output valid, status, found_value, key_hash, input ready);
	modport sink   (input valid, status, found_value, key_hash, output ready);
endinterface

/* rtl/ehklt_ctrl.sv */
// ----------------------------------------------------------------------------
// ehklt_ctrl
// Controller: request handshake and sequencing of the table scan.
// ----------------------------------------------------------------------------
module ehklt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  ehklt_pkg::ehklt_stat_t stat,
	output ehklt_pkg::ehklt_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} ehklt_state_t;

	ehklt_state_t state_q, state_d;

	always_comb begin
		state_d        = state_q;
		req_ready      = 1'b0;
		cmd.accept     = 1'b0;
		cmd.scan_issue = 1'b0;
		cmd.finish     = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready  = stat.out_free;
				cmd.accept = req_valid && stat.out_free;
				if (cmd.accept && stat.key_end) begin
					if (stat.tbl_empty) begin
						cmd.finish = 1'b1;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (stat.cmp_valid && (stat.cmp_hit || stat.cmp_last)) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/ehklt_dp.sv */
// ----------------------------------------------------------------------------
// ehklt_dp
// Datapath: hash accumulator, entry memories, scan pointer, result register.
// ----------------------------------------------------------------------------
module ehklt_dp #(
	parameter int unsigned DEPTH = ehklt_pkg::DEPTH_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         command,
	input  logic [ehklt_pkg::KEY_W-1:0]  new_key,
	input  logic [ehklt_pkg::VAL_W-1:0]  entry_value,
	input  logic [ehklt_pkg::BYTE_W-1:0] key_byte,
	input  ehklt_pkg::ehklt_cmd_t        cmd,
	output ehklt_pkg::ehklt_stat_t       stat,
	ehklt_rsp_if.source                  rsp
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

	logic [ehklt_pkg::KEY_W-1:0] key_mem [DEPTH];
	logic [ehklt_pkg::VAL_W-1:0] val_mem [DEPTH];

	logic [ehklt_pkg::KEY_W-1:0]  acc_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             issue_q;
	logic                         rd_valid_s1;
	logic [CNT_W-1:0]             idx_s1;
	logic [ehklt_pkg::KEY_W-1:0]  key_s1;
	logic [ehklt_pkg::VAL_W-1:0]  val_s1;
	logic                         rsp_valid_q;
	logic [ehklt_pkg::STAT_W-1:0] status_q;
	logic [ehklt_pkg::VAL_W-1:0]  found_q;
	logic [ehklt_pkg::HASH_W-1:0] hash_q;

	logic is_insert, is_byte, has_room, do_write, do_issue, hit;
	logic [ehklt_pkg::KEY_W-1:0] cmp_key;

	assign is_insert = (command == ehklt_pkg::CMD_INSERT);
	assign is_byte   = (command == ehklt_pkg::CMD_LOOKUP) && (key_byte != '0);
	assign has_room  = (count_q < DEPTH_C);
	assign do_write  = cmd.accept && is_insert && has_room;
	assign do_issue  = cmd.scan_issue && (issue_q < count_q) && !cmd.finish;
	assign cmp_key   = {1'b0, acc_q[ehklt_pkg::HASH_W-1:0]};
	assign hit       = rd_valid_s1 && (key_s1 == cmp_key);

	assign stat.key_end   = (command == ehklt_pkg::CMD_LOOKUP) && (key_byte == '0);
	assign stat.tbl_empty = (count_q == '0);
	assign stat.out_free  = !rsp_valid_q || rsp.ready;
	assign stat.cmp_valid = rd_valid_s1;
	assign stat.cmp_hit   = hit;
	assign stat.cmp_last  = ((idx_s1 + ONE_C) == count_q);

	always_ff @(posedge clk) begin
		if (do_write) begin
			key_mem[count_q[IDX_W-1:0]] <= new_key;
			val_mem[count_q[IDX_W-1:0]] <= entry_value;
		end
		key_s1 <= key_mem[issue_q[IDX_W-1:0]];
		val_s1 <= val_mem[issue_q[IDX_W-1:0]];
		idx_s1 <= issue_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			count_q     <= '0;
			issue_q     <= '0;
			rd_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				acc_q <= '0;
			end else if (cmd.accept && is_byte) begin
				acc_q <= ehklt_pkg::hash_step(acc_q, key_byte);
			end
			if (do_write) begin
				count_q <= count_q + ONE_C;
			end
			if (cmd.accept) begin
				issue_q <= '0;
			end else if (do_issue) begin
				issue_q <= issue_q + ONE_C;
			end
			rd_valid_s1 <= do_issue;
			if (cmd.finish || (cmd.accept && is_insert)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && is_insert) begin
			status_q <= has_room ? ehklt_pkg::ST_INSERTED : ehklt_pkg::ST_FULL;
			found_q  <= '0;
			hash_q   <= '0;
		end else if (cmd.finish) begin
			status_q <= hit ? ehklt_pkg::ST_HIT : ehklt_pkg::ST_MISS;
			found_q  <= hit ? val_s1 : '0;
			hash_q   <= acc_q[ehklt_pkg::HASH_W-1:0];
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.found_value = found_q;
	assign rsp.key_hash    = hash_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above depth");
	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |=> count_q == $past(count_q) + ONE_C)
		else $error("insert did not advance entry count");
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> rsp_valid_q && (acc_q == '0))
		else $error("lookup finish did not post result and clear hash");
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> idx_s1 < count_q)
		else $error("scan read beyond filled entries");
`endif

endmodule

/* rtl/elf_hash_keyed_lookup_table.sv */
// ----------------------------------------------------------------------------
// elf_hash_keyed_lookup_table
// Keyed table of DEPTH entries with a streaming ELF-hash lookup key.
// ----------------------------------------------------------------------------
// An insert transaction posts its status in the next cycle; a full table
// rejects it with status full. A nonzero key byte only updates the running
// hash. A zero byte ends the key: the table is then scanned from the oldest
// entry, one entry per cycle through the single read port of the key/value
// memory, stopping early at the first match; for an empty table the result
// is posted without a scan. No request is taken during the scan, and a
// request is taken only while the result register is free or being emptied
// in the same cycle.
module elf_hash_keyed_lookup_table #(
	parameter int unsigned DEPTH = ehklt_pkg::DEPTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	ehklt_req_if.sink    req,
	ehklt_rsp_if.source  rsp
);

	ehklt_pkg::ehklt_cmd_t  cmd;
	ehklt_pkg::ehklt_stat_t stat;
	logic                   ready;

	assign req.ready = ready;

	ehklt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ehklt_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.command     (req.command),
		.new_key     (req.new_key),
		.entry_value (req.entry_value),
		.key_byte    (req.key_byte),
		.cmd         (cmd),
		.stat        (stat),
		.rsp         (rsp)
	);

endmodule

/* tb/tb_elf_hash_keyed_lookup_table.sv */
// ----------------------------------------------------------------------------
// tb_elf_hash_keyed_lookup_table
// Self-checking testbench for the ELF-hash keyed lookup table. Inserts and
// key byte streams are driven over the request channel in random bursts. A
// local table and running hash predict each response, and the response
// channel is checked field by field while the receiver stalls on its own.
// ----------------------------------------------------------------------------
module tb_elf_hash_keyed_lookup_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = ehklt_pkg::DEPTH_DEFAULT;
	localparam int PHRASES      = 96;
	localparam int MAX_LEN      = 24;
	localparam int RANDOM_ITEMS = 1700;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = DEPTH + 8;
	localparam int IDLE_LIMIT   = 4000;

	typedef struct packed {
		logic [ehklt_pkg::STAT_W-1:0] status;
		logic [ehklt_pkg::VAL_W-1:0]  found_value;
		logic [ehklt_pkg::HASH_W-1:0] key_hash;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n;

	ehklt_req_if req_ch();
	ehklt_rsp_if rsp_ch();

	elf_hash_keyed_lookup_table #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// local copy of the table
	logic [ehklt_pkg::KEY_W-1:0] table_keys[DEPTH];
	logic [ehklt_pkg::VAL_W-1:0] table_vals[DEPTH];
	int                          table_fill = 0;
	logic [ehklt_pkg::KEY_W-1:0] running_hash = '0;
	table_result_t               expected_results[$];

	// key strings known to the stimulus
	logic [ehklt_pkg::BYTE_W-1:0] phrase_text[PHRASES][MAX_LEN];
	int                           phrase_len[PHRASES];
	int                           phrase_cnt = 0;

	int  fail_count = 0;
	int  items_accepted = 0;
	int  burst_left = 0;
	int  n_inserted = 0, n_full = 0, n_hit = 0, n_miss = 0;
	bit  hold_request = 1'b0;
	int  hold_left = 0;
	int  stall_mode = 0;
	int  stall_timer = 0;
	int  cycle_cnt = 0;
	int  idle_cycles = 0;

	function automatic logic [ehklt_pkg::KEY_W-1:0] elf_mix(
		input logic [ehklt_pkg::KEY_W-1:0] acc, input logic [ehklt_pkg::BYTE_W-1:0] b);
		logic [ehklt_pkg::KEY_W-1:0] t;
		logic [3:0]                  hi;
		t  = {acc[ehklt_pkg::KEY_W-5:0], 4'h0} + ehklt_pkg::KEY_W'(b);
		hi = t[31:28];
		t[7:4]   = t[7:4] ^ hi;
		t[31:28] = 4'h0;
		return t;
	endfunction

	function automatic void predict_transaction(input logic cmd,
		input logic [ehklt_pkg::KEY_W-1:0] k, input logic [ehklt_pkg::VAL_W-1:0] v,
		input logic [ehklt_pkg::BYTE_W-1:0] b);
		table_result_t r;
		r = '0;
		if (cmd == ehklt_pkg::CMD_INSERT) begin
			if (table_fill < DEPTH) begin
				table_keys[table_fill] = k;
				table_vals[table_fill] = v;
				table_fill++;
				r.status = ehklt_pkg::ST_INSERTED;
			end else begin
				r.status = ehklt_pkg::ST_FULL;
			end
			expected_results.push_back(r);
		end else if (b != '0) begin
			running_hash = elf_mix(running_hash, b);
		end else begin
			r.key_hash = running_hash[ehklt_pkg::HASH_W-1:0];
			r.status   = ehklt_pkg::ST_MISS;
			// reverse scan leaves the earliest match
			for (int i = table_fill - 1; i >= 0; i--) begin
				if (table_keys[i] == {1'b0, r.key_hash}) begin
					r.status      = ehklt_pkg::ST_HIT;
					r.found_value = table_vals[i];
				end
			end
			running_hash = '0;
			expected_results.push_back(r);
		end
	endfunction

	function automatic logic [ehklt_pkg::KEY_W-1:0] phrase_hash(input int idx);
		logic [ehklt_pkg::KEY_W-1:0] h;
		h = '0;
		for (int i = 0; i < phrase_len[idx]; i++) begin
			h = elf_mix(h, phrase_text[idx][i]);
		end
		return h;
	endfunction

	function automatic int new_phrase();
		int idx;
		if (phrase_cnt < PHRASES) begin
			idx = phrase_cnt;
			phrase_cnt++;
		end else begin
			idx = $urandom_range(0, PHRASES - 1);
		end
		phrase_len[idx] = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 8) :
			$urandom_range(9, MAX_LEN);
		for (int i = 0; i < phrase_len[idx]; i++) begin
			phrase_text[idx][i] = ehklt_pkg::BYTE_W'($urandom_range(1, 255));
		end
		return idx;
	endfunction

	function automatic logic [ehklt_pkg::KEY_W-1:0] pick_insert_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7 || phrase_cnt == 0) begin
			return phrase_hash(new_phrase());
		end else if (sel < 8) begin
			return phrase_hash($urandom_range(0, phrase_cnt - 1));
		end
		return $urandom;
	endfunction

	task automatic send_item(input logic cmd, input logic [ehklt_pkg::KEY_W-1:0] k,
		input logic [ehklt_pkg::VAL_W-1:0] v, input logic [ehklt_pkg::BYTE_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
		end
		req_ch.valid       <= 1'b1;
		req_ch.command     <= cmd;
		req_ch.new_key     <= k;
		req_ch.entry_value <= v;
		req_ch.key_byte    <= b;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predict_transaction(cmd, k, v, b);
		items_accepted++;
		burst_left--;
	endtask

	task automatic send_insert(input logic [ehklt_pkg::KEY_W-1:0] k,
		input logic [ehklt_pkg::VAL_W-1:0] v);
		send_item(ehklt_pkg::CMD_INSERT, k, v, ehklt_pkg::BYTE_W'($urandom));
	endtask

	task automatic send_byte(input logic [ehklt_pkg::BYTE_W-1:0] b);
		send_item(ehklt_pkg::CMD_LOOKUP, $urandom, $urandom, b);
	endtask

	task automatic lookup_phrase(input int idx);
		int split;
		split = ($urandom_range(0, 19) == 0) ? $urandom_range(0, phrase_len[idx]) : -1;
		for (int i = 0; i < phrase_len[idx]; i++) begin
			if (i == split) send_insert(pick_insert_key(), $urandom);
			send_byte(phrase_text[idx][i]);
		end
		if (split == phrase_len[idx]) send_insert(pick_insert_key(), $urandom);
		send_byte('0);
	endtask

	task automatic test_empty_table();
		send_byte('0);
		send_byte("a");
		send_byte("b");
		send_byte('0);
	endtask

	task automatic test_insert_and_hit();
		logic [ehklt_pkg::KEY_W-1:0] abc_key;
		abc_key = elf_mix(elf_mix(elf_mix('0, "a"), "b"), "c");
		send_insert(abc_key, 32'hffff_ffff);
		send_insert(32'hffff_ffff, 32'h0000_0000);
		send_insert(32'h0000_0000, 32'h1234_5678);
		send_insert(abc_key, 32'h0000_0000);
		send_byte("a");
		send_byte("b");
		send_byte("c");
		send_byte('0);
		send_byte('0);
	endtask

	task automatic test_insert_mid_key();
		send_byte("x");
		send_byte("y");
		send_insert(elf_mix(elf_mix(elf_mix('0, "x"), "y"), "z"), 32'h8000_0001);
		send_byte("z");
		send_byte('0);
	endtask

	task automatic test_long_key_fold();
		repeat (8) send_byte(8'hff);
		send_byte('0);
	endtask

	task automatic test_backpressure();
		hold_request = 1'b1;
		for (int i = 0; i < 16; i++) begin
			if (i % 4 == 0) send_insert(pick_insert_key(), $urandom);
			else send_byte('0);
		end
	endtask

	task automatic test_random_traffic();
		int stop_at;
		int pick;
		stop_at = items_accepted + RANDOM_ITEMS;
		while (items_accepted < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				send_insert(pick_insert_key(), $urandom);
			end else if (pick < 75 && phrase_cnt > 0) begin
				lookup_phrase($urandom_range(0, phrase_cnt - 1));
			end else begin
				lookup_phrase(new_phrase());
			end
		end
	endtask

	task automatic test_table_full();
		while (table_fill < DEPTH) send_insert(pick_insert_key(), $urandom);
		repeat (3) send_insert(pick_insert_key(), $urandom);
		if (phrase_cnt > 0) lookup_phrase($urandom_range(0, phrase_cnt - 1));
		send_byte('0);
	endtask

	// receiver: rotating stall patterns plus one long hold-off on request
	always @(posedge clk) begin
		cycle_cnt++;
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = HOLD_CYCLES - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			if (stall_timer == 0) begin
				stall_mode  = $urandom_range(0, 3);
				stall_timer = $urandom_range(16, 96);
			end
			stall_timer--;
			case (stall_mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= 1'($urandom_range(0, 1));
				2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ch.ready <= (cycle_cnt % 4 != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		table_result_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected response: status %0d value %h hash %h",
					rsp_ch.status, rsp_ch.found_value, rsp_ch.key_hash);
				fail_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (rsp_ch.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, rsp_ch.status);
					fail_count++;
				end
				if (rsp_ch.found_value !== exp_r.found_value) begin
					$error("found_value: expected %h, got %h", exp_r.found_value,
						rsp_ch.found_value);
					fail_count++;
				end
				if (rsp_ch.key_hash !== exp_r.key_hash) begin
					$error("key_hash: expected %h, got %h", exp_r.key_hash, rsp_ch.key_hash);
					fail_count++;
				end
				case (exp_r.status)
					ehklt_pkg::ST_INSERTED: n_inserted++;
					ehklt_pkg::ST_FULL:     n_full++;
					ehklt_pkg::ST_HIT:      n_hit++;
					default:                n_miss++;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
				$display("[elf_hash_keyed_lookup_table] ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.command     = ehklt_pkg::CMD_INSERT;
		req_ch.new_key     = '0;
		req_ch.entry_value = '0;
		req_ch.key_byte    = '0;
		rsp_ch.ready       = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_insert_and_hit();
		test_insert_mid_key();
		test_long_key_fold();
		test_backpressure();
		test_random_traffic();
		test_table_full();

		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d request transactions: %0d inserts, %0d full-table rejects,",
			items_accepted, n_inserted, n_full);
		$display("%0d lookup hits and %0d lookup misses checked.", n_hit, n_miss);
		if (fail_count == 0) begin
			$display("[elf_hash_keyed_lookup_table] OK");
		end else begin
			$display("[elf_hash_keyed_lookup_table] ERROR");
		end
		$finish;
	end

endmodule
